// ===== rtl/core/video_register_port_and_frame_timer_defines.svh =====
// Assertion macros for the register port and frame timer.
`ifndef VIDEO_REGISTER_PORT_AND_FRAME_TIMER_DEFINES_SVH
`define VIDEO_REGISTER_PORT_AND_FRAME_TIMER_DEFINES_SVH
`ifndef SYNTHESIS
`define VRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VRP_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define VRP_ASSERT(label, prop, msg)
`define VRP_NEVER(label, expr, msg)
`endif
`endif

// ===== rtl/core/vrp_pkg.sv =====
// Shared types, codes and helpers of the register port.
`timescale 1ns / 1ps
package vrp_pkg;
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_OADDR  = 3'd3;
  localparam logic [2:0] REG_ODATA  = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  localparam logic [20:0] DECAY_TICKS = 21'd1048576;
  localparam logic [8:0]  LINE_PRE    = 9'h1FF;

  // timer events of one tick
  typedef struct packed {
    logic vbl_set;
    logic vbl_clr;
  } tmr_evt_t;

  // palette entries at multiples of four fold onto the low half
  function automatic logic [4:0] pal_index(input logic [13:0] a);
    pal_index = (a[1:0] == 2'd0) ? {1'b0, a[3:0]} : a[4:0];
  endfunction

  function automatic logic is_palette(input logic [13:0] a);
    is_palette = (a[13:8] == 6'h3F);
  endfunction
endpackage

// ===== rtl/core/vrp_mem.sv =====
// Sprite and palette memories with per-entry valid bits.
`timescale 1ns / 1ps
module vrp_mem
  import vrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       spr_we,
  input  logic       spr_re,
  input  logic [7:0] spr_addr,
  input  logic [7:0] spr_wdata,
  input  logic       pal_we,
  input  logic       pal_re,
  input  logic [4:0] pal_addr,
  input  logic [5:0] pal_wdata,
  output logic [7:0] spr_q,
  output logic [5:0] pal_q
);
  logic [7:0]   spr_ram [256];
  logic [5:0]   pal_ram [32];
  logic [255:0] spr_vld;
  logic [31:0]  pal_vld;
  logic [7:0]   spr_raw;
  logic [5:0]   pal_raw;
  logic         spr_hit;
  logic         pal_hit;

  // storage arrays, read data registered
  always_ff @(posedge clk) begin
    if (spr_we) begin
      spr_ram[spr_addr] <= spr_wdata;
    end
    if (spr_re) begin
      spr_raw <= spr_ram[spr_addr];
    end
    if (pal_we) begin
      pal_ram[pal_addr] <= pal_wdata;
    end
    if (pal_re) begin
      pal_raw <= pal_ram[pal_addr];
    end
  end

  // valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      spr_vld <= '0;
      pal_vld <= '0;
      spr_hit <= 1'b0;
      pal_hit <= 1'b0;
    end else begin
      if (spr_we) spr_vld[spr_addr] <= 1'b1;
      if (pal_we) pal_vld[pal_addr] <= 1'b1;
      if (spr_re) spr_hit <= spr_vld[spr_addr];
      if (pal_re) pal_hit <= pal_vld[pal_addr];
    end
  end

  assign spr_q = spr_hit ? spr_raw : 8'h00;
  assign pal_q = pal_hit ? pal_raw : 6'h00;
endmodule

// ===== rtl/core/vrp_timer.sv =====
// Dot and line counter of the frame, with odd-frame short line.
`timescale 1ns / 1ps
module vrp_timer
  import vrp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     tick,
  input  logic     bg_on,
  output tmr_evt_t evt
);
  logic [8:0] dot;
  logic [8:0] line;
  logic       short_line;
  logic       odd_frame;
  logic       short_now;
  logic       wrap;

  // end-of-line detect, the short line is armed at dot 337
  always_comb begin
    short_now = short_line |
                ((line == LINE_PRE) && (dot == 9'd337) && odd_frame && bg_on);
    wrap = short_now ? (dot >= 9'd339) : (dot >= 9'd340);
    evt.vbl_set = tick && (line == 9'd241) && (dot == 9'd1);
    evt.vbl_clr = tick && (line == 9'd260) && (dot == 9'd340);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot        <= '0;
      line       <= LINE_PRE;
      short_line <= 1'b0;
      odd_frame  <= 1'b0;
    end else if (tick) begin
      if (evt.vbl_clr) odd_frame <= ~odd_frame;
      if (wrap) begin
        dot        <= '0;
        short_line <= 1'b0;
        line       <= (line == 9'd260) ? LINE_PRE : line + 9'd1;
      end else begin
        dot        <= dot + 9'd1;
        short_line <= short_now;
      end
    end
  end
endmodule

// ===== rtl/core/video_register_port_and_frame_timer.sv =====
// Top level: register port, frame timer and result pipeline.
// Pipeline: an accepted item passes the memory stage registers, then the output
// register; throughput is one item per cycle unless out_ready stalls the output,
// set by the single read and write port of each memory. Synchronous reset clears
// state and valid flags: frame at the prerender line, both memories read as zero.
`timescale 1ns / 1ps
`include "video_register_port_and_frame_timer_defines.svh"
module video_register_port_and_frame_timer
  import vrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [2:0]  reg_index,
  input  logic [7:0]  write_data,
  input  logic [7:0]  vram_read_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        nmi_pulse,
  output logic        vblank_start,
  output logic        mem_write,
  output logic [13:0] mem_write_address,
  output logic [7:0]  mem_write_data,
  output logic [13:0] next_read_address
);
  typedef enum logic [1:0] {SEL_BASE, SEL_SPR, SEL_PAL} sel_t;

  // architectural registers
  logic [7:0]  control_reg;
  logic [7:0]  mask_reg;
  logic        vblank;
  logic [7:0]  sprite_addr;
  logic [14:0] temp_address;
  logic [14:0] current_address;
  logic        write_toggle;
  logic [7:0]  read_buffer;
  logic [7:0]  open_bus;
  logic [20:0] decay_count;
  logic        bus_pend;

  // memory stage
  logic        s1_valid;
  sel_t        s1_sel;
  logic        s1_attr;
  logic [7:0]  s1_base;
  logic        s1_nmi;
  logic        s1_vbs;
  logic        s1_mw;
  logic [13:0] s1_mwa;
  logic [7:0]  s1_mwd;
  logic [13:0] s1_nra;
  logic [7:0]  s1_result;

  logic        in_fire;
  logic        s1_go;
  logic        tick_fire;
  tmr_evt_t    evt;
  logic [7:0]  spr_q;
  logic [5:0]  pal_q;
  logic [7:0]  ob_eff;
  logic [13:0] cur_a;

  // next values
  logic [7:0]  control_next;
  logic [7:0]  mask_next;
  logic        vblank_next;
  logic [7:0]  sprite_addr_next;
  logic [14:0] temp_next;
  logic [14:0] cur_next;
  logic        toggle_next;
  logic [7:0]  buffer_next;
  logic [7:0]  bus_next;
  logic [20:0] decay_next;
  logic        pend_next;
  sel_t        sel_next;
  logic        attr_next;
  logic [7:0]  base_next;
  logic        nmi_next;
  logic        mw_next;
  logic [13:0] mwa_next;
  logic [7:0]  mwd_next;
  logic [13:0] nra_next;
  logic        spr_we;
  logic        spr_re;
  logic        pal_we;
  logic        pal_re;
  logic [14:0] inc;

  assign s1_go     = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_go;
  assign in_fire   = in_valid && in_ready;
  assign tick_fire = in_fire && (operation == OP_TICK);
  assign cur_a     = current_address[13:0];
  assign inc       = control_reg[2] ? 15'd32 : 15'd1;

  // memory-dependent result and the open bus it forwards
  always_comb begin
    case (s1_sel)
      SEL_SPR: s1_result = spr_q & (s1_attr ? 8'hE3 : 8'hFF);
      SEL_PAL: s1_result = s1_base | {2'b00, pal_q};
      default: s1_result = s1_base;
    endcase
    ob_eff = bus_pend ? s1_result : open_bus;
  end

  vrp_mem u_mem (
    .clk       (clk),
    .rst       (rst),
    .spr_we    (spr_we),
    .spr_re    (spr_re),
    .spr_addr  (sprite_addr),
    .spr_wdata (write_data),
    .pal_we    (pal_we),
    .pal_re    (pal_re),
    .pal_addr  (pal_index(cur_a)),
    .pal_wdata (write_data[5:0]),
    .spr_q     (spr_q),
    .pal_q     (pal_q)
  );

  vrp_timer u_timer (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick_fire),
    .bg_on (mask_reg[3]),
    .evt   (evt)
  );

  // register port decode
  always_comb begin
    control_next     = control_reg;
    mask_next        = mask_reg;
    vblank_next      = vblank;
    sprite_addr_next = sprite_addr;
    temp_next        = temp_address;
    cur_next         = current_address;
    toggle_next      = write_toggle;
    buffer_next      = read_buffer;
    bus_next         = ob_eff;
    decay_next       = decay_count;
    pend_next        = 1'b0;
    sel_next         = SEL_BASE;
    attr_next        = 1'b0;
    base_next        = ob_eff;
    nmi_next         = 1'b0;
    mw_next          = 1'b0;
    mwa_next         = '0;
    mwd_next         = '0;
    spr_we           = 1'b0;
    spr_re           = 1'b0;
    pal_we           = 1'b0;
    pal_re           = 1'b0;
    case (operation)
      OP_READ: begin
        case (reg_index)
          REG_STATUS: begin
            base_next   = {vblank, 2'b00, ob_eff[4:0]};
            vblank_next = 1'b0;
            toggle_next = 1'b0;
          end
          REG_ODATA: begin
            spr_re     = in_fire;
            sel_next   = SEL_SPR;
            attr_next  = (sprite_addr[1:0] == 2'd2);
            pend_next  = 1'b1;
            decay_next = DECAY_TICKS;
          end
          REG_DATA: begin
            if (is_palette(cur_a)) begin
              pal_re    = in_fire;
              sel_next  = SEL_PAL;
              base_next = {ob_eff[7:6], 6'h00};
              pend_next = 1'b1;
            end else begin
              base_next = read_buffer;
              bus_next  = read_buffer;
            end
            buffer_next = vram_read_data;
            decay_next  = DECAY_TICKS;
            cur_next    = current_address + inc;
          end
          default: ;
        endcase
      end
      OP_WRITE: begin
        bus_next   = write_data;
        base_next  = write_data;
        decay_next = DECAY_TICKS;
        case (reg_index)
          REG_CTRL: begin
            control_next     = write_data;
            temp_next[11:10] = write_data[1:0];
            nmi_next = !control_reg[7] && write_data[7] && vblank;
          end
          REG_MASK:  mask_next = write_data;
          REG_OADDR: sprite_addr_next = write_data;
          REG_ODATA: begin
            spr_we           = in_fire;
            sprite_addr_next = sprite_addr + 8'd1;
          end
          REG_SCROLL: begin
            if (write_toggle) begin
              temp_next[9:5]   = write_data[7:3];
              temp_next[14:12] = write_data[2:0];
            end else begin
              temp_next[4:0] = write_data[7:3];
            end
            toggle_next = ~write_toggle;
          end
          REG_ADDR: begin
            if (write_toggle) begin
              temp_next = {temp_address[14:8], write_data};
              cur_next  = {temp_address[14:8], write_data};
            end else begin
              temp_next = {1'b0, write_data[5:0], temp_address[7:0]};
            end
            toggle_next = ~write_toggle;
          end
          REG_DATA: begin
            if (is_palette(cur_a)) begin
              pal_we = in_fire;
            end else begin
              mw_next  = 1'b1;
              mwa_next = cur_a;
              mwd_next = write_data;
            end
            cur_next = current_address + inc;
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (decay_count != 21'd0) begin
          decay_next = decay_count - 21'd1;
          if (decay_count == 21'd1) begin
            bus_next  = 8'h00;
            base_next = 8'h00;
          end
        end
        if (evt.vbl_set) begin
          vblank_next = 1'b1;
          nmi_next    = control_reg[7];
        end
        if (evt.vbl_clr) vblank_next = 1'b0;
      end
      default: ;
    endcase
    nra_next = is_palette(cur_next[13:0]) ? (14'h2F00 | {6'h00, cur_next[7:0]})
                                          : cur_next[13:0];
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg     <= '0;
      mask_reg        <= '0;
      vblank          <= 1'b0;
      sprite_addr     <= '0;
      temp_address    <= '0;
      current_address <= '0;
      write_toggle    <= 1'b0;
      read_buffer     <= '0;
      open_bus        <= '0;
      decay_count     <= '0;
      bus_pend        <= 1'b0;
    end else if (in_fire) begin
      control_reg     <= control_next;
      mask_reg        <= mask_next;
      vblank          <= vblank_next;
      sprite_addr     <= sprite_addr_next;
      temp_address    <= temp_next;
      current_address <= cur_next;
      write_toggle    <= toggle_next;
      read_buffer     <= buffer_next;
      open_bus        <= bus_next;
      decay_count     <= decay_next;
      bus_pend        <= pend_next;
    end else begin
      // commit a forwarded bus value
      open_bus <= ob_eff;
      bus_pend <= 1'b0;
    end
  end

  // memory stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) s1_valid <= 1'b1;
      else if (s1_go) s1_valid <= 1'b0;
      if (s1_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    if (in_fire) begin
      s1_sel  <= sel_next;
      s1_attr <= attr_next;
      s1_base <= base_next;
      s1_nmi  <= nmi_next;
      s1_vbs  <= evt.vbl_set;
      s1_mw   <= mw_next;
      s1_mwa  <= mwa_next;
      s1_mwd  <= mwd_next;
      s1_nra  <= nra_next;
    end
    if (s1_go) begin
      read_data         <= s1_result;
      nmi_pulse         <= s1_nmi;
      vblank_start      <= s1_vbs;
      mem_write         <= s1_mw;
      mem_write_address <= s1_mwa;
      mem_write_data    <= s1_mwd;
      next_read_address <= s1_nra;
    end
  end

  `VRP_ASSERT(a_pend_has_stage, bus_pend |-> s1_valid, "forwarded bus without stage")
  `VRP_NEVER(a_read_while_stalled, (spr_re || pal_re) && !in_fire, "memory read without transfer")
  `VRP_ASSERT(a_vblank_rise, $rose(vblank) |-> $past(tick_fire), "vblank set outside a tick")
  `VRP_ASSERT(a_vbs_sets_flag, (in_fire && evt.vbl_set) |=> vblank, "vblank start lost")
endmodule

// ===== verif/tb_video_register_port_and_frame_timer.sv =====
// Testbench for the register port and frame timer, checked against a cycle-free predictor.
`timescale 1ns / 1ps
module tb_video_register_port_and_frame_timer;
  import vrp_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0]  rd;
    logic        nmi;
    logic        vbs;
    logic        mw;
    logic [13:0] mwa;
    logic [7:0]  mwd;
    logic [13:0] nra;
  } port_result_t;

  // Predicts each result of the port and holds the results still owed
  class register_port_ledger;
    logic [7:0]  ctrl, mask_r, oaddr, rbuf, bus;
    logic [2:0]  flags, fx;
    logic [14:0] temp, cur;
    bit          toggle, odd;
    logic [20:0] decay;
    int          dot, line, len;
    logic [7:0]  oam [256];
    logic [5:0]  pal [32];
    port_result_t pending_results[$];
    int          errors;

    function new();
      ctrl = 0; mask_r = 0; oaddr = 0; rbuf = 0; bus = 0; flags = 0; fx = 0;
      temp = 0; cur = 0; toggle = 0; odd = 0; decay = 0;
      dot = 0; line = -1; len = 341; errors = 0;
      foreach (oam[i]) oam[i] = 0;
      foreach (pal[i]) pal[i] = 0;
    endfunction

    function logic [4:0] pal_slot(logic [13:0] a);
      return (a[1:0] == 2'd0) ? {1'b0, a[3:0]} : a[4:0];
    endfunction

    function void touch_bus(logic [7:0] v);
      bus = v;
      decay = DECAY_TICKS;
    endfunction

    function void step_cur();
      cur = cur + (ctrl[2] ? 15'd32 : 15'd1);
    endfunction

    function void note_item(logic [1:0] op, logic [2:0] rg, logic [7:0] wd, logic [7:0] ext);
      port_result_t e;
      logic [13:0] a;
      e = '0;
      a = cur[13:0];
      case (op)
        OP_READ: begin
          e.rd = bus;
          if (rg == REG_STATUS) begin
            e.rd = {flags, bus[4:0]};
            flags[2] = 1'b0;
            toggle = 0;
          end else if (rg == REG_ODATA) begin
            e.rd = oam[oaddr];
            if (oaddr[1:0] == 2'd2) e.rd &= 8'hE3;
            touch_bus(e.rd);
          end else if (rg == REG_DATA) begin
            e.rd = rbuf;
            if (a >= 14'h3F00) e.rd = {bus[7:6], pal[pal_slot(a)]};
            rbuf = ext;
            touch_bus(e.rd);
            step_cur();
          end
        end
        OP_WRITE: begin
          touch_bus(wd);
          case (rg)
            REG_CTRL: begin
              if (!ctrl[7] && wd[7] && flags[2]) e.nmi = 1'b1;
              ctrl = wd;
              temp[11:10] = wd[1:0];
            end
            REG_MASK: mask_r = wd;
            REG_OADDR: oaddr = wd;
            REG_ODATA: begin
              oam[oaddr] = wd;
              oaddr = oaddr + 8'd1;
            end
            REG_SCROLL: begin
              if (toggle) begin
                temp[9:5] = wd[7:3];
                temp[14:12] = wd[2:0];
              end else begin
                temp[4:0] = wd[7:3];
                fx = wd[2:0];
              end
              toggle = !toggle;
            end
            REG_ADDR: begin
              if (toggle) begin
                temp[7:0] = wd;
                cur = temp;
              end else begin
                temp = {1'b0, wd[5:0], temp[7:0]};
              end
              toggle = !toggle;
            end
            REG_DATA: begin
              if (a >= 14'h3F00) begin
                pal[pal_slot(a)] = wd[5:0];
              end else begin
                e.mw = 1'b1;
                e.mwa = a;
                e.mwd = wd;
              end
              step_cur();
            end
            default: ;
          endcase
          e.rd = bus;
        end
        OP_TICK: begin
          if (decay != 0) begin
            decay--;
            if (decay == 0) bus = 0;
          end
          if (line == -1 && dot == 337 && odd && mask_r[3]) len = 340;
          if (line == 241 && dot == 1) begin
            flags[2] = 1'b1;
            e.nmi = ctrl[7];
            e.vbs = 1'b1;
          end
          if (line == 260 && dot == 340) begin
            flags = 0;
            odd = !odd;
          end
          dot++;
          if (dot >= len) begin
            dot = 0;
            len = 341;
            line++;
            if (line >= 261) line = -1;
          end
          e.rd = bus;
        end
        default: e.rd = bus;
      endcase
      e.nra = (cur[13:0] >= 14'h3F00) ? {6'h2F, cur[7:0]} : cur[13:0];
      pending_results.push_back(e);
    endfunction

    function void check_result(port_result_t got);
      port_result_t e;
      if (pending_results.size() == 0) begin
        if (errors < 10) $display("unexpected result %p", got);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (got !== e) begin
        if (errors < 10)
          $display("mismatch at %0t: expected %p, got %p", $realtime, e, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  operation = 0;
  logic [2:0]  reg_index = 0;
  logic [7:0]  write_data = 0;
  logic [7:0]  vram_read_data = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [7:0]  read_data;
  logic        nmi_pulse, vblank_start, mem_write;
  logic [13:0] mem_write_address, next_read_address;
  logic [7:0]  mem_write_data;

  register_port_ledger ledger = new();
  bit gaps_on = 1;
  bit hold_req = 0;
  int idle_cycles = 0;

  video_register_port_and_frame_timer DUT (.*);

  always #4 clk = ~clk;

  // compare every result transfer
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      ledger.check_result({read_data, nmi_pulse, vblank_start, mem_write,
                           mem_write_address, mem_write_data, next_read_address});
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    int w;
    do @(negedge clk); while (rst);
    forever begin
      w = gaps_on ? $urandom_range(0, 19) : 0;
      if (hold_req) begin
        w = HOLD_CYCLES;
        hold_req = 0;
      end
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  task automatic send(input logic [1:0] op, input logic [2:0] rg,
                      input logic [7:0] wd, input logic [7:0] vd);
    int w;
    w = gaps_on ? $urandom_range(0, 19) : 0;
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(negedge clk);
    end
    operation <= op;
    reg_index <= rg;
    write_data <= wd;
    vram_read_data <= vd;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    ledger.note_item(op, rg, wd, vd);
    @(negedge clk);
  endtask

  task automatic send_rw(input logic [1:0] op, input logic [2:0] rg, input logic [7:0] wd);
    send(op, rg, wd, 8'($urandom));
  endtask

  // status read to clear the toggle, then the address pair
  task automatic set_address(input logic [7:0] hi, input logic [7:0] lo);
    send_rw(OP_READ, REG_STATUS, 8'h00);
    send_rw(OP_WRITE, REG_ADDR, hi);
    send_rw(OP_WRITE, REG_ADDR, lo);
  endtask

  task automatic random_group();
    int n;
    logic [7:0] hi;
    case ($urandom_range(0, 7))
      0, 1: begin
        hi = ($urandom_range(0, 1) != 0) ? {2'($urandom), 6'h3F} : 8'($urandom);
        set_address(hi, 8'($urandom));
        n = $urandom_range(1, 6);
        repeat (n) send_rw($urandom_range(0, 1) ? OP_WRITE : OP_READ, REG_DATA,
                           8'($urandom));
      end
      2: begin
        send_rw(OP_WRITE, REG_OADDR, 8'($urandom));
        n = $urandom_range(1, 4);
        repeat (n) send_rw($urandom_range(0, 1) ? OP_WRITE : OP_READ, REG_ODATA,
                           8'($urandom));
      end
      3: begin
        send_rw(OP_WRITE, REG_SCROLL, 8'($urandom));
        send_rw(OP_WRITE, REG_SCROLL, 8'($urandom));
      end
      4: send_rw(OP_WRITE, $urandom_range(0, 1) ? REG_CTRL : REG_MASK, 8'($urandom));
      5: begin
        n = $urandom_range(1, 30);
        repeat (n) send_rw(OP_TICK, 3'($urandom), 8'($urandom));
      end
      default: send_rw(2'($urandom), 3'($urandom), 8'($urandom));
    endcase
  endtask

  initial begin
    bit nmi_armed;
    int i, k;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: every register read, unused code, status write
    for (k = 0; k < 8; k++) send(OP_READ, 3'(k), 8'h00, (k % 2) ? 8'hFF : 8'h00);
    send(OP_WRITE, REG_STATUS, 8'hA5, 8'h00);
    send(OP_NONE, REG_DATA, 8'hFF, 8'hFF);
    // sprite attribute byte read is masked
    send(OP_WRITE, REG_OADDR, 8'h02, 8'h00);
    send(OP_WRITE, REG_ODATA, 8'hFF, 8'h00);
    send(OP_WRITE, REG_OADDR, 8'h02, 8'h00);
    send(OP_READ, REG_ODATA, 8'h00, 8'h00);
    // palette mirror: entry 0x10 lands on entry 0
    set_address(8'h3F, 8'h10);
    send(OP_WRITE, REG_DATA, 8'hFF, 8'h00);
    set_address(8'hFF, 8'h00);
    send(OP_READ, REG_DATA, 8'h00, 8'hFF);
    send(OP_READ, REG_DATA, 8'h00, 8'h00);
    // step by 32 from the top of the palette, then back to 1
    send(OP_WRITE, REG_CTRL, 8'hFF, 8'h00);
    set_address(8'h3F, 8'hFF);
    send(OP_WRITE, REG_DATA, 8'h00, 8'h00);
    send(OP_WRITE, REG_CTRL, 8'h00, 8'h00);
    send(OP_WRITE, REG_SCROLL, 8'hFF, 8'h00);
    send(OP_WRITE, REG_SCROLL, 8'h00, 8'h00);

    // back-to-back tick run with occasional register reads
    gaps_on = 0;
    send_rw(OP_WRITE, REG_MASK, 8'h08);
    send_rw(OP_WRITE, REG_CTRL, 8'h80);
    nmi_armed = 0;
    for (i = 0; i < 200; i++) begin
      if (!nmi_armed && ledger.line == 250) begin
        send_rw(OP_WRITE, REG_CTRL, 8'h00);
        send_rw(OP_WRITE, REG_CTRL, 8'h80);
        nmi_armed = 1;
      end else if ($urandom_range(0, 1999) == 0) begin
        send_rw(OP_READ, $urandom_range(0, 1) ? REG_STATUS : REG_MASK, 8'h00);
      end
      send_rw(OP_TICK, 3'($urandom), 8'($urandom));
    end

    // random register traffic with idle stretches and one long output hold
    for (i = 0; i < 250; i++) begin
      if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (i == 125) begin
        gaps_on = 0;
        hold_req = 1;
      end
      random_group();
    end
    in_valid <= 0;

    while (ledger.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
